FILE: rtl/core/apt_pkg.sv
package apt_pkg;

  // Register lanes are 16 bits wide whatever the coefficient width.
  localparam int LANE_BITS = 16;
  localparam int NUM_ROWS  = 4;
  localparam int NUM_AXES  = 3;
  localparam int CORNERS   = 8;
  localparam int REG_BITS  = 64;

  localparam logic [REG_BITS-1:0] ROW_ZERO_RST  = 64'h0000_0000_0000_1000;
  localparam logic [REG_BITS-1:0] ROW_ONE_RST   = 64'h0000_0000_1000_0000;
  localparam logic [REG_BITS-1:0] ROW_TWO_RST   = 64'h0000_1000_0000_0000;
  localparam logic [REG_BITS-1:0] ROW_THREE_RST = 64'h1000_0000_0000_0000;

  typedef enum logic [1:0] {
    REG_ROW_ZERO  = 2'd0,
    REG_ROW_ONE   = 2'd1,
    REG_ROW_TWO   = 2'd2,
    REG_ROW_THREE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_W_BAD = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

  // Per-corner control carried alongside the datapath.
  typedef struct packed {
    logic first;
    logic last;
    logic wbad;
  } tag_t;

endpackage

FILE: rtl/core/apt_fifo.sv
module apt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wptr_r, wptr_nxt;
  logic [PTR_BITS-1:0] rptr_r, rptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == CNT_BITS'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/core/apt_xform.sv
module apt_xform #(
  parameter int COORD_BITS = 16,
  parameter int COEF_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   box_valid,
  input  logic                                   credit_ok,
  output logic                                   box_take,
  input  logic signed [COORD_BITS-1:0]           lo_i [apt_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0]           hi_i [apt_pkg::NUM_AXES],
  input  logic [apt_pkg::REG_BITS-1:0]           rows_i [apt_pkg::NUM_ROWS],
  output logic                                   val_o,
  output apt_pkg::tag_t                          tag_o,
  output logic signed [COORD_BITS+COEF_BITS+1:0] h_o [apt_pkg::NUM_ROWS]
);

  localparam int PW    = COORD_BITS + COEF_BITS;
  localparam int HW    = PW + 2;
  localparam int CFRAC = COORD_BITS - 8;
  localparam int NA    = apt_pkg::NUM_AXES;
  localparam int NR    = apt_pkg::NUM_ROWS;

  // Corner sequencer
  logic                         busy_r, busy_nxt;
  logic [2:0]                   corner_r, corner_nxt;
  logic signed [COORD_BITS-1:0] blo_r [NA];
  logic signed [COORD_BITS-1:0] bhi_r [NA];
  logic                         issue;

  // Stage 1: corner coordinates
  logic                         val1_r;
  apt_pkg::tag_t                tag1_r, tag1_nxt;
  logic signed [COORD_BITS-1:0] v_r [NA];
  logic signed [COORD_BITS-1:0] v_nxt [NA];

  // Stage 2: products
  logic                         val2_r;
  apt_pkg::tag_t                tag2_r;
  logic signed [COEF_BITS-1:0]  coef [NR][NR];
  logic signed [PW-1:0]         prod_r [NR][NA];
  logic signed [PW-1:0]         prod_nxt [NR][NA];
  logic signed [PW-1:0]         cterm_r [NR];
  logic signed [PW-1:0]         cterm_nxt [NR];

  // Stage 3: row sums
  logic                         val3_r;
  apt_pkg::tag_t                tag3_r;
  logic signed [HW-1:0]         h_r [NR];
  logic signed [HW-1:0]         h_nxt [NR];

  assign box_take = !busy_r && box_valid && credit_ok;
  assign issue    = busy_r || box_take;

  always_comb begin
    busy_nxt   = busy_r;
    corner_nxt = corner_r;
    if (box_take) begin
      busy_nxt   = 1'b1;
      corner_nxt = 3'd1;
    end else if (busy_r) begin
      corner_nxt = corner_r + 3'd1;
      if (corner_r == 3'(apt_pkg::CORNERS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
    // Corner bit 2 picks x, bit 1 y, bit 0 z; the first corner is all minimum.
    if (box_take) begin
      for (int j = 0; j < NA; j++) begin
        v_nxt[j] = lo_i[j];
      end
    end else begin
      v_nxt[0] = corner_r[2] ? bhi_r[0] : blo_r[0];
      v_nxt[1] = corner_r[1] ? bhi_r[1] : blo_r[1];
      v_nxt[2] = corner_r[0] ? bhi_r[2] : blo_r[2];
    end
    tag1_nxt.first = box_take;
    tag1_nxt.last  = busy_r && (corner_r == 3'(apt_pkg::CORNERS - 1));
    tag1_nxt.wbad  = 1'b0;
  end

  always_comb begin
    for (int r = 0; r < NR; r++) begin
      for (int j = 0; j < NR; j++) begin
        coef[r][j] = rows_i[r][apt_pkg::LANE_BITS*j +: COEF_BITS];
      end
    end
    for (int r = 0; r < NR; r++) begin
      for (int j = 0; j < NA; j++) begin
        prod_nxt[r][j] = PW'(coef[r][j]) * PW'(v_r[j]);
      end
      // w of the input corner is one, so the last column is a plain shift.
      cterm_nxt[r] = PW'(coef[r][NR-1]) <<< CFRAC;
    end
    for (int r = 0; r < NR; r++) begin
      h_nxt[r] = HW'(prod_r[r][0]) + HW'(prod_r[r][1]) + HW'(prod_r[r][2])
               + HW'(cterm_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      corner_r <= '0;
      val1_r   <= 1'b0;
      val2_r   <= 1'b0;
      val3_r   <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      corner_r <= corner_nxt;
      val1_r   <= issue;
      val2_r   <= val1_r;
      val3_r   <= val2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (box_take) begin
      for (int j = 0; j < NA; j++) begin
        blo_r[j] <= lo_i[j];
        bhi_r[j] <= hi_i[j];
      end
    end
    tag1_r <= tag1_nxt;
    tag2_r <= tag1_r;
    tag3_r <= tag2_r;
    for (int j = 0; j < NA; j++) begin
      v_r[j] <= v_nxt[j];
    end
    for (int r = 0; r < NR; r++) begin
      for (int j = 0; j < NA; j++) begin
        prod_r[r][j] <= prod_nxt[r][j];
      end
      cterm_r[r] <= cterm_nxt[r];
      h_r[r]     <= h_nxt[r];
    end
  end

  assign val_o = val3_r;
  assign tag_o = tag3_r;
  always_comb begin
    for (int r = 0; r < NR; r++) begin
      h_o[r] = h_r[r];
    end
  end

endmodule

FILE: rtl/core/apt_div.sv
module apt_div #(
  parameter int COORD_BITS = 16,
  parameter int COEF_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   val_i,
  input  apt_pkg::tag_t                          tag_i,
  input  logic signed [COORD_BITS+COEF_BITS+1:0] h_i [apt_pkg::NUM_ROWS],
  output logic                                   val_o,
  output apt_pkg::tag_t                          tag_o,
  output logic signed [COORD_BITS-1:0]           p_o [apt_pkg::NUM_AXES],
  output logic [apt_pkg::NUM_AXES-1:0]           sat_o
);

  localparam int HW    = COORD_BITS + COEF_BITS + 2;
  localparam int DW    = HW + COORD_BITS;
  localparam int CFRAC = COORD_BITS - 8;
  localparam int NA    = apt_pkg::NUM_AXES;
  localparam int NS    = COORD_BITS + 1;

  // Front stage: sign, magnitude, divisor
  logic                  val_a_r;
  apt_pkg::tag_t         tag_a_r, tag_a_nxt;
  logic [NA-1:0]         neg_a_r, neg_a_nxt;
  logic [DW-1:0]         num_a_r [NA];
  logic [DW-1:0]         num_a_nxt [NA];
  logic [HW-2:0]         den_a_r;
  logic [HW-1:0]         mag;

  // Restoring steps: stage 0 checks overflow, stage i yields quotient bit CB-i
  logic                  val_s_r [NS];
  apt_pkg::tag_t         tag_s_r [NS];
  logic [HW-2:0]         den_s_r [NS];
  logic [NA-1:0]         neg_s_r [NS];
  logic [NA-1:0]         ovf_s_r [NS];
  logic [NA-1:0]         ovf_s_nxt [NS];
  logic [DW-1:0]         rem_s_r [NS][NA];
  logic [DW-1:0]         rem_s_nxt [NS][NA];
  logic [COORD_BITS-1:0] q_s_r [NS][NA];
  logic [COORD_BITS-1:0] q_s_nxt [NS][NA];
  logic [DW-1:0]         dsh;
  logic                  ge;

  // Output stage
  logic                         val_o_r;
  apt_pkg::tag_t                tag_o_r;
  logic signed [COORD_BITS-1:0] p_r [NA];
  logic signed [COORD_BITS-1:0] p_nxt [NA];
  logic [NA-1:0]                sat_r, sat_nxt;
  logic [COORD_BITS:0]          qx, limit;

  always_comb begin
    tag_a_nxt      = tag_i;
    tag_a_nxt.wbad = h_i[NA][HW-1] || (h_i[NA] == '0);
    for (int l = 0; l < NA; l++) begin
      neg_a_nxt[l] = h_i[l][HW-1];
      mag          = neg_a_nxt[l] ? HW'(-h_i[l]) : HW'(h_i[l]);
      num_a_nxt[l] = DW'(mag) << CFRAC;
    end
  end

  always_comb begin
    dsh = '0;
    ge  = 1'b0;
    for (int l = 0; l < NA; l++) begin
      dsh             = DW'(den_a_r) << COORD_BITS;
      ovf_s_nxt[0][l] = (num_a_r[l] >= dsh);
      rem_s_nxt[0][l] = num_a_r[l];
      q_s_nxt[0][l]   = '0;
    end
    for (int i = 1; i < NS; i++) begin
      for (int l = 0; l < NA; l++) begin
        dsh             = DW'(den_s_r[i-1]) << (COORD_BITS - i);
        ge              = (rem_s_r[i-1][l] >= dsh);
        rem_s_nxt[i][l] = ge ? rem_s_r[i-1][l] - dsh : rem_s_r[i-1][l];
        q_s_nxt[i][l]   = q_s_r[i-1][l];
        q_s_nxt[i][l][COORD_BITS-i] = ge;
        ovf_s_nxt[i][l] = ovf_s_r[i-1][l];
      end
    end
  end

  // Clamp to the output range; the negative side reaches one step further.
  always_comb begin
    qx    = '0;
    limit = '0;
    for (int l = 0; l < NA; l++) begin
      qx    = ovf_s_r[NS-1][l] ? ((COORD_BITS+1)'(1) << COORD_BITS)
                               : {1'b0, q_s_r[NS-1][l]};
      limit = ((COORD_BITS+1)'(1) << (COORD_BITS - 1))
            - (neg_s_r[NS-1][l] ? (COORD_BITS+1)'(0) : (COORD_BITS+1)'(1));
      sat_nxt[l] = (qx > limit);
      if (sat_nxt[l]) begin
        qx = limit;
      end
      p_nxt[l] = neg_s_r[NS-1][l] ? -qx[COORD_BITS-1:0] : qx[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_a_r <= 1'b0;
      val_o_r <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        val_s_r[i] <= 1'b0;
      end
    end else begin
      val_a_r    <= val_i;
      val_s_r[0] <= val_a_r;
      for (int i = 1; i < NS; i++) begin
        val_s_r[i] <= val_s_r[i-1];
      end
      val_o_r <= val_s_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    tag_a_r <= tag_a_nxt;
    neg_a_r <= neg_a_nxt;
    den_a_r <= h_i[NA][HW-2:0];
    for (int l = 0; l < NA; l++) begin
      num_a_r[l] <= num_a_nxt[l];
    end
    tag_s_r[0] <= tag_a_r;
    den_s_r[0] <= den_a_r;
    neg_s_r[0] <= neg_a_r;
    for (int i = 1; i < NS; i++) begin
      tag_s_r[i] <= tag_s_r[i-1];
      den_s_r[i] <= den_s_r[i-1];
      neg_s_r[i] <= neg_s_r[i-1];
    end
    for (int i = 0; i < NS; i++) begin
      ovf_s_r[i] <= ovf_s_nxt[i];
      for (int l = 0; l < NA; l++) begin
        rem_s_r[i][l] <= rem_s_nxt[i][l];
        q_s_r[i][l]   <= q_s_nxt[i][l];
      end
    end
    tag_o_r <= tag_s_r[NS-1];
    sat_r   <= sat_nxt;
    for (int l = 0; l < NA; l++) begin
      p_r[l] <= p_nxt[l];
    end
  end

  assign val_o = val_o_r;
  assign tag_o = tag_o_r;
  assign sat_o = sat_r;
  always_comb begin
    for (int l = 0; l < NA; l++) begin
      p_o[l] = p_r[l];
    end
  end

endmodule

FILE: rtl/core/apt_bound.sv
module apt_bound #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         val_i,
  input  apt_pkg::tag_t                tag_i,
  input  logic signed [COORD_BITS-1:0] p_i [apt_pkg::NUM_AXES],
  input  logic [apt_pkg::NUM_AXES-1:0] sat_i,
  output logic                         push_o,
  output logic signed [COORD_BITS-1:0] lo_o [apt_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0] hi_o [apt_pkg::NUM_AXES],
  output apt_pkg::status_t             status_o
);

  localparam int NA = apt_pkg::NUM_AXES;

  logic                         any_r, any_nxt;
  logic                         wbad_r, wbad_nxt;
  logic                         sat_r, sat_nxt;
  logic signed [COORD_BITS-1:0] lo_r [NA];
  logic signed [COORD_BITS-1:0] lo_nxt [NA];
  logic signed [COORD_BITS-1:0] hi_r [NA];
  logic signed [COORD_BITS-1:0] hi_nxt [NA];
  logic                         base_any, base_wbad, base_sat;

  logic                         push_r;
  logic signed [COORD_BITS-1:0] res_lo_r [NA];
  logic signed [COORD_BITS-1:0] res_hi_r [NA];
  apt_pkg::status_t             status_r, status_nxt;

  always_comb begin
    base_any  = tag_i.first ? 1'b0 : any_r;
    base_wbad = tag_i.first ? 1'b0 : wbad_r;
    base_sat  = tag_i.first ? 1'b0 : sat_r;
    any_nxt   = any_r;
    wbad_nxt  = wbad_r;
    sat_nxt   = sat_r;
    for (int j = 0; j < NA; j++) begin
      lo_nxt[j] = lo_r[j];
      hi_nxt[j] = hi_r[j];
    end
    if (val_i) begin
      any_nxt  = base_any || !tag_i.wbad;
      wbad_nxt = base_wbad || tag_i.wbad;
      sat_nxt  = base_sat || (!tag_i.wbad && (|sat_i));
      // Skip a corner behind the eye; widen the box with every other one.
      if (!tag_i.wbad) begin
        for (int j = 0; j < NA; j++) begin
          if (!base_any || (p_i[j] < lo_r[j])) begin
            lo_nxt[j] = p_i[j];
          end
          if (!base_any || (p_i[j] > hi_r[j])) begin
            hi_nxt[j] = p_i[j];
          end
        end
      end
    end
    priority if (wbad_nxt) begin
      status_nxt = apt_pkg::STATUS_W_BAD;
    end else if (sat_nxt) begin
      status_nxt = apt_pkg::STATUS_SAT;
    end else begin
      status_nxt = apt_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r  <= 1'b0;
      wbad_r <= 1'b0;
      sat_r  <= 1'b0;
      push_r <= 1'b0;
    end else begin
      any_r  <= any_nxt;
      wbad_r <= wbad_nxt;
      sat_r  <= sat_nxt;
      push_r <= val_i && tag_i.last;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    for (int j = 0; j < NA; j++) begin
      lo_r[j]     <= lo_nxt[j];
      hi_r[j]     <= hi_nxt[j];
      res_lo_r[j] <= any_nxt ? lo_nxt[j] : '0;
      res_hi_r[j] <= any_nxt ? hi_nxt[j] : '0;
    end
  end

  assign push_o   = push_r;
  assign status_o = status_r;
  always_comb begin
    for (int j = 0; j < NA; j++) begin
      lo_o[j] = res_lo_r[j];
      hi_o[j] = res_hi_r[j];
    end
  end

endmodule

FILE: rtl/core/aabb_projective_transform_core.sv
// Projective transform of an axis-aligned box. Push a box (minimum and maximum
// corner, signed fixed point with COORD_BITS-8 fraction bits); pop the box that
// bounds its eight corners after the 4x4 matrix in row_zero..row_three and the
// divide by w. Each row register holds four 16-bit lanes, column 0 in the low
// lane, each a signed coefficient in its low COEF_BITS bits with COEF_BITS-4
// fraction bits; reset loads the identity. Registers sit at byte address 8*i.
// Write them only while no transaction is in flight. status reads 1 when some
// corner had w of zero or less (that corner is left out; with no usable corner
// all bounds read zero), else 2 when a coordinate saturated, else 0.
// Rate: one corner per cycle through the shared multiply array and pipelined
// divider; boxes follow back to back while a box is queued and a result slot
// is free. A two-entry input queue decouples the front from the corner
// sequencer, and a four-entry result queue lets the pipeline run while pop is
// low: the sequencer starts a box only when a result slot is reserved for it.
module aabb_projective_transform_core #(
  parameter int COORD_BITS = 16,
  parameter int COEF_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input queue
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] in_box_min_x,
  input  logic signed [COORD_BITS-1:0] in_box_min_y,
  input  logic signed [COORD_BITS-1:0] in_box_min_z,
  input  logic signed [COORD_BITS-1:0] in_box_max_x,
  input  logic signed [COORD_BITS-1:0] in_box_max_y,
  input  logic signed [COORD_BITS-1:0] in_box_max_z,
  // result queue
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] out_min_x,
  output logic signed [COORD_BITS-1:0] out_min_y,
  output logic signed [COORD_BITS-1:0] out_min_z,
  output logic signed [COORD_BITS-1:0] out_max_x,
  output logic signed [COORD_BITS-1:0] out_max_y,
  output logic signed [COORD_BITS-1:0] out_max_z,
  output logic [1:0]                   out_status,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  localparam int NA        = apt_pkg::NUM_AXES;
  localparam int NR        = apt_pkg::NUM_ROWS;
  localparam int HW        = COORD_BITS + COEF_BITS + 2;
  localparam int IN_DEPTH  = 2;
  localparam int OUT_DEPTH = 4;
  localparam int IN_W      = 2 * NA * COORD_BITS;
  localparam int OUT_W     = 2 * NA * COORD_BITS + 2;
  localparam int RES_BITS  = $clog2(OUT_DEPTH + 1);

  // Matrix rows
  logic [apt_pkg::REG_BITS-1:0] rows_r [NR];
  logic                         cfg_wr;
  apt_pkg::reg_idx_t            cfg_idx;

  // Input queue
  logic [IN_W-1:0]              in_wdata, in_rdata;
  logic                         in_empty;
  logic                         box_take;
  logic signed [COORD_BITS-1:0] box_lo [NA];
  logic signed [COORD_BITS-1:0] box_hi [NA];

  // Result slots reserved by started boxes and not yet popped
  logic [RES_BITS-1:0]          reserved_r, reserved_nxt;
  logic                         credit_ok;
  logic                         out_pop_acc;

  // Datapath links
  logic                         xf_val;
  apt_pkg::tag_t                xf_tag;
  logic signed [HW-1:0]         xf_h [NR];
  logic                         dv_val;
  apt_pkg::tag_t                dv_tag;
  logic signed [COORD_BITS-1:0] dv_p [NA];
  logic [NA-1:0]                dv_sat;
  logic                         bd_push;
  logic signed [COORD_BITS-1:0] bd_lo [NA];
  logic signed [COORD_BITS-1:0] bd_hi [NA];
  apt_pkg::status_t             bd_status;
  logic [OUT_W-1:0]             out_wdata, out_rdata;
  logic                         out_full;

  // Configuration: zero-wait APB, address bits above the 8-byte word pick the row.
  assign pready  = 1'b1;
  assign cfg_idx = apt_pkg::reg_idx_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[0] <= apt_pkg::ROW_ZERO_RST;
      rows_r[1] <= apt_pkg::ROW_ONE_RST;
      rows_r[2] <= apt_pkg::ROW_TWO_RST;
      rows_r[3] <= apt_pkg::ROW_THREE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        apt_pkg::REG_ROW_ZERO:  rows_r[0] <= pwdata;
        apt_pkg::REG_ROW_ONE:   rows_r[1] <= pwdata;
        apt_pkg::REG_ROW_TWO:   rows_r[2] <= pwdata;
        apt_pkg::REG_ROW_THREE: rows_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      apt_pkg::REG_ROW_ZERO:  prdata = rows_r[0];
      apt_pkg::REG_ROW_ONE:   prdata = rows_r[1];
      apt_pkg::REG_ROW_TWO:   prdata = rows_r[2];
      apt_pkg::REG_ROW_THREE: prdata = rows_r[3];
      default:                prdata = '0;
    endcase
  end

  // Front: queue incoming boxes.
  assign in_wdata = {in_box_max_z, in_box_max_y, in_box_max_x,
                     in_box_min_z, in_box_min_y, in_box_min_x};

  apt_fifo #(
    .WIDTH (IN_W),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (in_wdata),
    .full  (full),
    .pop   (box_take),
    .rdata (in_rdata),
    .empty (in_empty)
  );

  always_comb begin
    for (int j = 0; j < NA; j++) begin
      box_lo[j] = in_rdata[j*COORD_BITS +: COORD_BITS];
      box_hi[j] = in_rdata[(j+NA)*COORD_BITS +: COORD_BITS];
    end
  end

  // Hold a new box back until its result has a guaranteed queue slot.
  assign out_pop_acc = pop && !empty;
  assign credit_ok   = (reserved_r < RES_BITS'(OUT_DEPTH));

  always_comb begin
    reserved_nxt = reserved_r;
    if (box_take && !out_pop_acc) begin
      reserved_nxt = reserved_r + 1'b1;
    end else if (out_pop_acc && !box_take) begin
      reserved_nxt = reserved_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= '0;
    end else begin
      reserved_r <= reserved_nxt;
    end
  end

  // Back: corners, matrix product, divide, bounds.
  apt_xform #(
    .COORD_BITS (COORD_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .box_valid (!in_empty),
    .credit_ok (credit_ok),
    .box_take  (box_take),
    .lo_i      (box_lo),
    .hi_i      (box_hi),
    .rows_i    (rows_r),
    .val_o     (xf_val),
    .tag_o     (xf_tag),
    .h_o       (xf_h)
  );

  apt_div #(
    .COORD_BITS (COORD_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .val_i (xf_val),
    .tag_i (xf_tag),
    .h_i   (xf_h),
    .val_o (dv_val),
    .tag_o (dv_tag),
    .p_o   (dv_p),
    .sat_o (dv_sat)
  );

  apt_bound #(
    .COORD_BITS (COORD_BITS)
  ) u_bound (
    .clk      (clk),
    .rst_n    (rst_n),
    .val_i    (dv_val),
    .tag_i    (dv_tag),
    .p_i      (dv_p),
    .sat_i    (dv_sat),
    .push_o   (bd_push),
    .lo_o     (bd_lo),
    .hi_o     (bd_hi),
    .status_o (bd_status)
  );

  // Result queue: never overflows thanks to the slot reservation above.
  assign out_wdata = {bd_status, bd_hi[2], bd_hi[1], bd_hi[0],
                      bd_lo[2], bd_lo[1], bd_lo[0]};

  apt_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bd_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign out_min_x  = out_rdata[0*COORD_BITS +: COORD_BITS];
  assign out_min_y  = out_rdata[1*COORD_BITS +: COORD_BITS];
  assign out_min_z  = out_rdata[2*COORD_BITS +: COORD_BITS];
  assign out_max_x  = out_rdata[3*COORD_BITS +: COORD_BITS];
  assign out_max_y  = out_rdata[4*COORD_BITS +: COORD_BITS];
  assign out_max_z  = out_rdata[5*COORD_BITS +: COORD_BITS];
  // The reservation keeps the result queue from filling while a push is due,
  // so its full flag adds nothing to the status.
  assign out_status = out_rdata[OUT_W-1 -: 2] | {1'b0, out_full & 1'b0};

endmodule
